// ===== design/cfr_pkg.sv =====
// Shared constants, phase codes and the result record of the frame receiver.
package cfr_pkg;

  // Frame format
  localparam int          BUF_SIZE    = 128;
  localparam logic [7:0]  SYNC_FIRST  = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND = 8'hFB;
  localparam logic [7:0]  TYPE_LIMIT  = 8'hF1;
  localparam logic [8:0]  LEN_LIMIT   = 9'(BUF_SIZE);

  // Payload capture window
  localparam int CAP_DEPTH = 16;
  localparam int CAP_IDX_W = $clog2(CAP_DEPTH);

  // Parser phase codes
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_TYPE    = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;

  localparam logic STATUS_MATCH    = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [7:0]  payload_length;
    logic        status;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;
  } result_t;

endpackage

// ===== design/cfr_if.sv =====
// Valid/ready channel interfaces for received bytes and frame results.
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_type;
  logic [7:0]  payload_length;
  logic        status;
  logic [31:0] word_zero;
  logic [31:0] word_one;
  logic [31:0] word_two;
  logic [31:0] word_three;

  modport source (output valid, output frame_type, output payload_length, output status,
                  output word_zero, output word_one, output word_two, output word_three,
                  input ready);
  modport sink   (input valid, input frame_type, input payload_length, input status,
                  input word_zero, input word_one, input word_two, input word_three,
                  output ready);
endinterface

// ===== design/cfr_parser.sv =====
// Frame parser: phase register, running sum and payload capture, one byte per cycle while beats are accepted.
module cfr_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             beat,
  input  logic [7:0]       beat_byte,
  output logic             res_valid,
  output cfr_pkg::result_t res
);
  import cfr_pkg::*;

  logic [2:0] phase, phase_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] count, count_next;
  logic [7:0] sum, sum_next;
  logic [7:0] held_type, held_type_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] payload [CAP_DEPTH];
  logic       clear_payload;
  logic       capture;
  logic [7:0] remaining_dec;

  assign remaining_dec = remaining - 8'd1;

  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    count_next       = count;
    sum_next         = sum;
    held_type_next   = held_type;
    held_length_next = held_length;
    clear_payload    = 1'b0;
    capture          = 1'b0;
    res_valid        = 1'b0;
    unique case (phase)
      PH_SYNC2: begin
        if (beat_byte == SYNC_SECOND) begin
          phase_next = PH_TYPE;
          sum_next   = sum + beat_byte;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_TYPE: begin
        if (beat_byte < TYPE_LIMIT) begin
          phase_next     = PH_LENGTH;
          held_type_next = beat_byte;
          sum_next       = sum + beat_byte;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LENGTH: begin
        if (beat_byte != 8'd0 && {1'b0, beat_byte} < LEN_LIMIT) begin
          phase_next       = PH_PAYLOAD;
          held_length_next = beat_byte;
          remaining_next   = beat_byte;
          count_next       = 8'd0;
          sum_next         = sum + beat_byte;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (remaining == 8'd0) begin
          phase_next = PH_HUNT;
        end else begin
          capture        = (count < 8'(CAP_DEPTH));
          count_next     = count + 8'd1;
          remaining_next = remaining_dec;
          sum_next       = sum + beat_byte;
          if (remaining_dec == 8'd0) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        phase_next = PH_HUNT;
        res_valid  = beat;
      end
      default: begin
        // hunt, and the unused codes
        if (beat_byte == SYNC_FIRST) begin
          phase_next     = PH_SYNC2;
          sum_next       = beat_byte;
          count_next     = 8'd0;
          remaining_next = 8'd0;
          clear_payload  = 1'b1;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  always_comb begin
    res.frame_type     = held_type;
    res.payload_length = held_length;
    res.status         = (beat_byte == sum) ? STATUS_MATCH : STATUS_MISMATCH;
    res.word_zero      = {payload[3], payload[2], payload[1], payload[0]};
    res.word_one       = {payload[7], payload[6], payload[5], payload[4]};
    res.word_two       = {payload[11], payload[10], payload[9], payload[8]};
    res.word_three     = {payload[15], payload[14], payload[13], payload[12]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      remaining   <= 8'd0;
      count       <= 8'd0;
      sum         <= 8'd0;
      held_type   <= 8'd0;
      held_length <= 8'd0;
    end else if (beat) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      count       <= count_next;
      sum         <= sum_next;
      held_type   <= held_type_next;
      held_length <= held_length_next;
    end
  end

  // Payload bytes hold no reset: a new frame always clears them on its first sync byte.
  always_ff @(posedge clk) begin
    if (beat) begin
      if (clear_payload) begin
        for (int i = 0; i < CAP_DEPTH; i++) begin
          payload[i] <= 8'd0;
        end
      end else if (capture) begin
        payload[count[CAP_IDX_W-1:0]] <= beat_byte;
      end
    end
  end

endmodule

// ===== design/cfr_out_buf.sv =====
// Result register with a skid entry, so input acceptance waits on the sink's ready only once the skid entry is full.
module cfr_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cfr_pkg::result_t push_data,
  output logic             room,
  output logic             main_valid,
  output cfr_pkg::result_t main_data,
  input  logic             pop_ready
);
  import cfr_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign room = !skid_valid;
  assign pop  = main_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

// ===== design/checksummed_frame_receiver_top.sv =====
// Top level of the checksummed frame receiver.
//
// Usage:
//   rx  - sink channel, one received link byte per beat (rx_byte).
//   res - source channel, one beat per completed frame: type, length, status
//         (0 checksum good, 1 checksum bad) and the first 16 payload bytes as
//         four little-endian 32-bit words, zero beyond the frame length.
// The parser hunts for 0xFF 0xFB, a type below 0xF1, a length of 1 to
// BUF_SIZE-1, the payload and a checksum byte; any byte that breaks the
// pattern is dropped and the hunt restarts from the first sync byte.
// Throughput: one byte per cycle, sustained, while the sink keeps up.
// Result timing: with the result register empty, the result beat shows on
// res in the cycle after the checksum beat is accepted; the parser's result
// is combinational between its state registers and the result register.
// Stall: the result register has a skid entry behind it. rx.ready falls only
// when both hold a result, i.e. after the sink has stalled across two frames;
// it rises again the cycle after the sink takes a beat.
// Reset (rst, synchronous, active high): the parser returns to hunting, both
// result entries empty; rx.ready is low in reset and high from the next cycle.
module checksummed_frame_receiver_top (
  input logic          clk,
  input logic          rst,
  cfr_byte_if.sink     rx,
  cfr_result_if.source res
);
  import cfr_pkg::*;

  logic    beat;
  logic    room;
  logic    parse_valid;
  result_t parse_res;
  logic    out_valid;
  result_t out_res;

  // Take a byte whenever the skid entry is free and reset is released.
  assign rx.ready = room && !rst;
  assign beat     = rx.valid && rx.ready;

  cfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .beat_byte (rx.rx_byte),
    .res_valid (parse_valid),
    .res       (parse_res)
  );

  cfr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (parse_valid),
    .push_data  (parse_res),
    .room       (room),
    .main_valid (out_valid),
    .main_data  (out_res),
    .pop_ready  (res.ready)
  );

  // Drive the result channel from the result register.
  assign res.valid          = out_valid;
  assign res.frame_type     = out_res.frame_type;
  assign res.payload_length = out_res.payload_length;
  assign res.status         = out_res.status;
  assign res.word_zero      = out_res.word_zero;
  assign res.word_one       = out_res.word_one;
  assign res.word_two       = out_res.word_two;
  assign res.word_three     = out_res.word_three;

endmodule

// ===== design/cfr_checker.sv =====
// Port-level assertions for the frame receiver, bound to the top level.
module cfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] frame_type,
  input logic [7:0] payload_length
);
  import cfr_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat offered right after reset");

  // Input side is open straight out of reset.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> rx_ready)
    else $error("rx not ready after reset");

  // A fresh result only follows an accepted byte.
  a_result_from_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(rx_valid && rx_ready))
    else $error("result appeared without an accepted byte");

  // Reported header fields are always within the frame format.
  a_header_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_type < TYPE_LIMIT && payload_length != 8'd0 &&
                   {1'b0, payload_length} < LEN_LIMIT))
    else $error("result header out of range");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(frame_type) && $stable(payload_length))
    else $error("stalled result beat changed");

endmodule

bind checksummed_frame_receiver_top cfr_checker u_cfr_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_valid       (rx.valid),
  .rx_ready       (rx.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .frame_type     (res.frame_type),
  .payload_length (res.payload_length)
);
